FILE: design/pmnc_pkg.sv
// Shared constants for the particulate NowCast block.
package pmnc_pkg;

    // Window length in hours and the index width it needs
    localparam int WINDOW_HOURS = 12;
    localparam int IDX_W        = $clog2(WINDOW_HOURS);

    // Field widths
    localparam int HIST_W = 16;           // hourly concentration
    localparam int W_W    = 17;           // weight, Q0.16 up to 1.0
    localparam int WFRAC  = 16;           // fraction bits of the weight
    localparam int OUT_W  = 20;           // result, Q16.4
    localparam int OFRAC  = 4;            // fraction bits of the result

    // Power of the weight in Q0.32, up to 1.0
    localparam int P_W    = 33;
    localparam int PROD_W = P_W + W_W;

    // Accumulators: sums of WINDOW_HOURS terms
    localparam int SUM_GROW = $clog2(WINDOW_HOURS);
    localparam int DEN_W    = P_W + SUM_GROW;
    localparam int NUM_W    = P_W + HIST_W + SUM_GROW;

    // Shared divider: quotient holds the Q16.4 result plus one bit
    localparam int QUO_W   = OUT_W + 1;
    localparam int NUMER_W = DEN_W + QUO_W;

    localparam logic [W_W-1:0] W_ONE          = W_W'(1) << WFRAC;
    localparam logic [W_W-1:0] W_FLOOR_RESET  = W_W'(1) << (WFRAC - 1);
    localparam logic [P_W-1:0] P_ONE          = P_W'(1) << (2 * WFRAC);

endpackage

FILE: design/pmnc_div.sv
// Restoring divider, one quotient bit per cycle.
module pmnc_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pmnc_pkg::NUMER_W-1:0]     dividend,
    input  logic [pmnc_pkg::DEN_W-1:0]       divisor,
    output logic                             done,
    output logic [pmnc_pkg::QUO_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(pmnc_pkg::QUO_W);

    logic [pmnc_pkg::DEN_W-1:0] rem_reg;
    logic [pmnc_pkg::DEN_W-1:0] dvs_reg;
    logic [pmnc_pkg::QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [pmnc_pkg::DEN_W:0]   shifted;
    logic [pmnc_pkg::DEN_W:0]   diff;
    logic                       qbit;

    // Quotient must fit in QUO_W bits, so the top part of the dividend
    // starts below the divisor.
    assign shifted = {rem_reg, quo_reg[pmnc_pkg::QUO_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign qbit    = ~diff[pmnc_pkg::DEN_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(pmnc_pkg::QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[pmnc_pkg::NUMER_W-1:pmnc_pkg::QUO_W];
            quo_reg <= dividend[pmnc_pkg::QUO_W-1:0];
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= qbit ? diff[pmnc_pkg::DEN_W-1:0] : shifted[pmnc_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[pmnc_pkg::QUO_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/pm_nowcast_weighted_average.sv
// Top level of the 12-hour particulate NowCast with a shared multiplier and divider.
// Channels: s_valid / s_ready / s_hour_concentration take one hourly
//   concentration word; m_valid / m_ready return one word per input with
//   m_nowcast_value (Q16.4, saturated) and m_weight_used (Q0.16, after the
//   floor). cfg_wr_en / cfg_wr_data write weight_floor (Q0.16);
//   write it only while the block is idle. Values above 1.0 act as 1.0.
// Sequence: after a word is accepted, the sequencer runs a min/max scan over
//   the window, a check, a pass through the shared restoring divider for the
//   weight, a walk over the window with one 33x17 multiplier (two products
//   per hour), a state that starts the final divide, a second divider pass
//   for the final quotient and a load into the output register. An all-zero
//   window skips the arithmetic.
// Flow: s_ready is high only in the idle state, which returns together
//   with m_valid, so a new word is taken only after the last one's result
//   has been loaded into the output register.
// Reset: aresetn (synchronous, active low) clears the history to zero, sets
//   the weight floor to 0.5 and empties the output register.
// Stalls: a finished result waits in the output register; the next word is
//   taken once it is loaded there, and its own result then holds the
//   sequencer, with s_ready low, until the output register frees up.
module pm_nowcast_weighted_average (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pmnc_pkg::HIST_W-1:0]   s_hour_concentration,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pmnc_pkg::OUT_W-1:0]    m_nowcast_value,
    output logic [pmnc_pkg::W_W-1:0]      m_weight_used,
    input  logic                          cfg_wr_en,
    input  logic [pmnc_pkg::W_W-1:0]      cfg_wr_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_WDIV   = 3'd3;
    localparam logic [2:0] ST_MAC    = 3'd4;
    localparam logic [2:0] ST_FSTART = 3'd5;
    localparam logic [2:0] ST_FDIV   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    localparam logic [pmnc_pkg::IDX_W-1:0] IDX_LAST =
        pmnc_pkg::IDX_W'(pmnc_pkg::WINDOW_HOURS - 1);

    logic [2:0]                    state_reg, state_next;
    logic [pmnc_pkg::IDX_W-1:0]    idx_reg;
    logic                          phase_reg;
    logic [pmnc_pkg::W_W-1:0]      weight_floor_reg;
    logic                          m_valid_reg;

    // History: entry 0 is the newest hour
    logic [pmnc_pkg::HIST_W-1:0]   hist_reg [pmnc_pkg::WINDOW_HOURS];
    logic [pmnc_pkg::HIST_W-1:0]   hist_rd;

    logic [pmnc_pkg::HIST_W-1:0]   cmin_reg, cmax_reg;
    logic [pmnc_pkg::W_W-1:0]      w_reg;
    logic [pmnc_pkg::P_W-1:0]      p_reg;
    logic [pmnc_pkg::PROD_W-1:0]   prod_reg;
    logic [pmnc_pkg::NUM_W-1:0]    num_reg;
    logic [pmnc_pkg::DEN_W-1:0]    den_reg;
    logic [pmnc_pkg::OUT_W-1:0]    res_value_reg;
    logic [pmnc_pkg::W_W-1:0]      res_weight_reg;
    logic [pmnc_pkg::OUT_W-1:0]    m_value_reg;
    logic [pmnc_pkg::W_W-1:0]      m_weight_reg;

    logic                          s_fire;
    logic                          out_load;
    logic [pmnc_pkg::P_W-1:0]      p_cur;
    logic [pmnc_pkg::P_W-1:0]      mul_a;
    logic [pmnc_pkg::W_W-1:0]      mul_b;
    logic [pmnc_pkg::PROD_W-1:0]   mul_p;
    logic [pmnc_pkg::W_W-1:0]      floor_w;
    logic [pmnc_pkg::W_W-1:0]      w_div;
    logic [pmnc_pkg::W_W-1:0]      w_sel;
    logic [pmnc_pkg::QUO_W-1:0]    div_quo;
    logic                          div_done;
    logic                          div_start;
    logic [pmnc_pkg::NUMER_W-1:0]  div_dividend;
    logic [pmnc_pkg::DEN_W-1:0]    div_divisor;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign hist_rd  = hist_reg[idx_reg];

    // Weight: clamp the floor to 1.0, then raise the ratio to it
    assign floor_w = (weight_floor_reg > pmnc_pkg::W_ONE) ? pmnc_pkg::W_ONE
                                                          : weight_floor_reg;
    assign w_div   = div_quo[pmnc_pkg::W_W-1:0];
    assign w_sel   = (w_div < floor_w) ? floor_w : w_div;

    // Power walk: the first hour uses 1.0, later ones take the last p*w >> 16
    assign p_cur = (idx_reg == '0) ? pmnc_pkg::P_ONE
                 : prod_reg[pmnc_pkg::WFRAC+pmnc_pkg::P_W-1:pmnc_pkg::WFRAC];
    assign mul_a = phase_reg ? p_reg : p_cur;
    assign mul_b = phase_reg ? w_reg : {1'b0, hist_rd};
    assign mul_p = pmnc_pkg::PROD_W'(mul_a) * pmnc_pkg::PROD_W'(mul_b);

    // Divider operands: weight ratio in CHECK, final average in FSTART
    always_comb begin
        div_start    = 1'b0;
        div_dividend = pmnc_pkg::NUMER_W'({num_reg, pmnc_pkg::OFRAC'(0)})
                     + pmnc_pkg::NUMER_W'(den_reg >> 1);
        div_divisor  = den_reg;
        case (state_reg)
            ST_CHECK: begin
                div_start    = (cmax_reg != '0);
                div_dividend = pmnc_pkg::NUMER_W'({cmin_reg, pmnc_pkg::WFRAC'(0)});
                div_divisor  = pmnc_pkg::DEN_W'(cmax_reg);
            end
            ST_FSTART: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    pmnc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_SCAN;
            ST_SCAN:   if (idx_reg == IDX_LAST) state_next = ST_CHECK;
            ST_CHECK:  state_next = (cmax_reg == '0) ? ST_DONE : ST_WDIV;
            ST_WDIV:   if (div_done) state_next = ST_MAC;
            ST_MAC:    if (phase_reg && idx_reg == IDX_LAST) state_next = ST_FSTART;
            ST_FSTART: state_next = ST_FDIV;
            ST_FDIV:   if (div_done) state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state, history and the floor register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            phase_reg        <= 1'b0;
            weight_floor_reg <= pmnc_pkg::W_FLOOR_RESET;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < pmnc_pkg::WINDOW_HOURS; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                weight_floor_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    idx_reg   <= '0;
                    phase_reg <= 1'b0;
                    // shift the new hour in, drop the oldest
                    if (s_fire) begin
                        hist_reg[0] <= s_hour_concentration;
                        for (int i = 1; i < pmnc_pkg::WINDOW_HOURS; i++) begin
                            hist_reg[i] <= hist_reg[i-1];
                        end
                    end
                end
                ST_SCAN: begin
                    idx_reg <= (idx_reg == IDX_LAST) ? '0
                             : idx_reg + pmnc_pkg::IDX_W'(1);
                end
                ST_MAC: begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg) begin
                        idx_reg <= (idx_reg == IDX_LAST) ? '0
                                 : idx_reg + pmnc_pkg::IDX_W'(1);
                    end
                end
                default: begin
                    phase_reg <= 1'b0;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmin_reg <= '1;
                cmax_reg <= '0;
            end
            ST_SCAN: begin
                if (hist_rd < cmin_reg) cmin_reg <= hist_rd;
                if (hist_rd > cmax_reg) cmax_reg <= hist_rd;
            end
            ST_CHECK: begin
                // empty window: report zero value and zero weight
                res_value_reg  <= '0;
                res_weight_reg <= '0;
            end
            ST_WDIV: begin
                num_reg <= '0;
                den_reg <= '0;
                if (div_done) w_reg <= w_sel;
            end
            ST_MAC: begin
                prod_reg <= mul_p;
                if (!phase_reg) begin
                    p_reg <= p_cur;
                end else begin
                    num_reg <= num_reg + pmnc_pkg::NUM_W'(prod_reg);
                    den_reg <= den_reg + pmnc_pkg::DEN_W'(p_reg);
                end
            end
            ST_FDIV: begin
                if (div_done) begin
                    res_value_reg  <= div_quo[pmnc_pkg::QUO_W-1] ? '1
                                    : div_quo[pmnc_pkg::OUT_W-1:0];
                    res_weight_reg <= w_reg;
                end
            end
            default: begin
                res_value_reg <= res_value_reg;
            end
        endcase
        if (out_load) begin
            m_value_reg  <= res_value_reg;
            m_weight_reg <= res_weight_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_nowcast_value = m_value_reg;
    assign m_weight_used   = m_weight_reg;

endmodule

FILE: tb/sv/pm_nowcast_checker.sv
// Checker for the NowCast block: watches both channels, predicts each result word and compares.
`timescale 1ns / 1ps

module pm_nowcast_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [pmnc_pkg::HIST_W-1:0] s_hour_concentration,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [pmnc_pkg::OUT_W-1:0]  m_nowcast_value,
    input  logic [pmnc_pkg::W_W-1:0]    m_weight_used,
    input  logic                        cfg_wr_en,
    input  logic [pmnc_pkg::W_W-1:0]    cfg_wr_data,
    output int                          fault_count,
    output int                          words_due
);

    typedef struct packed {
        logic [pmnc_pkg::OUT_W-1:0] nowcast;
        logic [pmnc_pkg::W_W-1:0]   weight;
    } nowcast_word_t;

    // Shadow copy of the block state and its one register
    logic [pmnc_pkg::HIST_W-1:0] hours [pmnc_pkg::WINDOW_HOURS];
    int unsigned                 newest;
    logic [pmnc_pkg::W_W-1:0]    floor_q16;

    nowcast_word_t     nowcast_due [$];
    int unsigned       word_index;

    task automatic report_mismatch(input string msg);
        fault_count = fault_count + 1;
        $display("nowcast check, result word %0d: %s", word_index, msg);
    endtask

    // Write one hour into the ring, then form the weighted average over the window.
    task automatic advance_window(input logic [pmnc_pkg::HIST_W-1:0] conc,
                                  output nowcast_word_t want);
        logic [pmnc_pkg::HIST_W-1:0] lo;
        logic [pmnc_pkg::HIST_W-1:0] hi;
        logic [pmnc_pkg::W_W-1:0]    w;
        logic [pmnc_pkg::W_W-1:0]    fl;
        logic [63:0]                 p;
        logic [63:0]                 num;
        logic [63:0]                 den;
        logic [63:0]                 q;
        int unsigned                 at;
        newest = (newest + 1 >= pmnc_pkg::WINDOW_HOURS) ? 0 : newest + 1;
        hours[newest] = conc;
        lo = '1;
        hi = '0;
        for (int k = 0; k < pmnc_pkg::WINDOW_HOURS; k++) begin
            if (hours[k] < lo) lo = hours[k];
            if (hours[k] > hi) hi = hours[k];
        end
        if (hi == '0) begin
            want = '0;
            return;
        end
        w  = pmnc_pkg::W_W'((64'(lo) << pmnc_pkg::WFRAC) / 64'(hi));
        fl = (floor_q16 > pmnc_pkg::W_ONE) ? pmnc_pkg::W_ONE : floor_q16;
        if (w < fl) w = fl;
        p   = 64'(pmnc_pkg::P_ONE);
        num = '0;
        den = '0;
        at  = newest;
        for (int k = 0; k < pmnc_pkg::WINDOW_HOURS; k++) begin
            num = num + p * 64'(hours[at]);
            den = den + p;
            p   = (p * 64'(w)) >> pmnc_pkg::WFRAC;
            at  = (at == 0) ? pmnc_pkg::WINDOW_HOURS - 1 : at - 1;
        end
        q = ((num << pmnc_pkg::OFRAC) + den / 2) / den;
        if (q > 64'({pmnc_pkg::OUT_W{1'b1}})) q = 64'({pmnc_pkg::OUT_W{1'b1}});
        want.nowcast = pmnc_pkg::OUT_W'(q);
        want.weight  = w;
    endtask

    always @(posedge aclk) begin
        nowcast_word_t want;
        if (!aresetn) begin
            for (int k = 0; k < pmnc_pkg::WINDOW_HOURS; k++) hours[k] = '0;
            newest     = 0;
            floor_q16  = pmnc_pkg::W_FLOOR_RESET;
            word_index = 0;
            nowcast_due.delete();
        end else begin
            // retire the result word first so a same-edge accept never pairs with itself
            if (m_valid && m_ready) begin
                if (nowcast_due.size() == 0) begin
                    report_mismatch($sformatf("arrived with none expected (value %0d, weight %0d)",
                                              m_nowcast_value, m_weight_used));
                end else begin
                    want = nowcast_due.pop_front();
                    if (m_nowcast_value !== want.nowcast)
                        report_mismatch($sformatf("nowcast_value %0d, want %0d",
                                                  m_nowcast_value, want.nowcast));
                    if (m_weight_used !== want.weight)
                        report_mismatch($sformatf("weight_used %0d, want %0d",
                                                  m_weight_used, want.weight));
                end
                word_index = word_index + 1;
            end
            if (cfg_wr_en) floor_q16 = cfg_wr_data;
            if (s_valid && s_ready) begin
                advance_window(s_hour_concentration, want);
                nowcast_due.push_back(want);
            end
        end
        words_due = nowcast_due.size();
    end

endmodule

FILE: tb/sv/pm_nowcast_weighted_average_test.sv
// Top of the NowCast testbench: clock, reset, stimulus, output stalls and the verdict.
`timescale 1ns / 1ps

module pm_nowcast_weighted_average_test;

    localparam int RANDOM_WORDS = 1750;
    localparam int CALM_WORDS   = 200;      // tail of the run with no idling on either side
    localparam int CYCLE_LIMIT  = 1500000;  // worst case per word, several times over, for every word
    localparam int DRAIN_CYCLES = 200;      // watch for stray result words after the last one

    localparam logic [pmnc_pkg::W_W-1:0] W_FLOOR_ZERO = '0;
    localparam logic [pmnc_pkg::W_W-1:0] W_FLOOR_TOP  = '1;

    // Shapes of the random hour traffic
    typedef enum int {
        SHAPE_UNIFORM,   // full 16-bit range, weight usually floored
        SHAPE_NARROW,    // values close together, weight near 1.0
        SHAPE_LOW,       // tiny values, lots of zero minima
        SHAPE_RUNS,      // constant runs, zero runs empty the window
        SHAPE_SPIKES     // mostly small with rare near-full-scale hours
    } hour_shape_t;

    logic                        aclk                 = 1'b0;
    logic                        aresetn              = 1'b0;
    logic                        s_valid              = 1'b0;
    logic [pmnc_pkg::HIST_W-1:0] s_hour_concentration = '0;
    logic                        m_ready              = 1'b0;
    logic                        cfg_wr_en            = 1'b0;
    logic [pmnc_pkg::W_W-1:0]    cfg_wr_data          = '0;

    logic                        s_ready;
    logic                        m_valid;
    logic [pmnc_pkg::OUT_W-1:0]  m_nowcast_value;
    logic [pmnc_pkg::W_W-1:0]    m_weight_used;

    int fault_count;
    int words_due;
    bit calm        = 1'b0;
    int stall_left  = 0;
    int cycle_count = 0;

    pm_nowcast_weighted_average dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_hour_concentration (s_hour_concentration),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_nowcast_value      (m_nowcast_value),
        .m_weight_used        (m_weight_used),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data)
    );

    pm_nowcast_checker checker_i (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_hour_concentration (s_hour_concentration),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_nowcast_value      (m_nowcast_value),
        .m_weight_used        (m_weight_used),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .fault_count          (fault_count),
        .words_due            (words_due)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: drop ready at random, hold it high in the calm tail.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count = cycle_count + 1;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offer one hour word, maybe after a short gap, and return at the edge that takes it.
    // Valid stays high afterwards so back-to-back words never drop it.
    task automatic send_hour(input logic [pmnc_pkg::HIST_W-1:0] conc);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_hour_concentration <= conc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid and hold the sender until every expected result word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
    endtask

    // Write the weight floor while the block is idle.
    task automatic write_floor(input logic [pmnc_pkg::W_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        hour_shape_t                 shape;
        logic [pmnc_pkg::W_W-1:0]    floor_pick;
        logic [pmnc_pkg::HIST_W-1:0] conc;
        logic [pmnc_pkg::HIST_W-1:0] base;
        logic [pmnc_pkg::HIST_W-1:0] run_value;
        int                          run_left;
        int                          burst;
        int                          sent;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset floor of 0.5.
        // An all-zero window gives a zero result and zero weight.
        send_hour(16'd0);
        send_hour(16'd0);
        // Full scale against unfilled zero hours: weight floored.
        send_hour(16'hFFFF);
        send_hour(16'd1);
        send_hour(16'hFFFF);
        send_hour(16'h8000);

        // Zero floor: a zero minimum leaves the weight at zero, newest hour alone counts.
        write_floor(W_FLOOR_ZERO);
        send_hour(16'd0);
        send_hour(16'd100);
        send_hour(16'hFFFF);

        // Floor at 1.0: plain average over the window.
        write_floor(pmnc_pkg::W_ONE);
        send_hour(16'd7);
        send_hour(16'hFFFF);

        // Floor above 1.0 acts as 1.0.
        write_floor(W_FLOOR_TOP);
        send_hour(16'd12345);

        // Back to 0.5 and fill the window with one value: minimum equals maximum.
        write_floor(pmnc_pkg::W_FLOOR_RESET);
        repeat (pmnc_pkg::WINDOW_HOURS) send_hour(16'd500);

        // Random part: phases of one floor setting and one traffic shape each.
        sent     = 0;
        run_left = 0;
        run_value = '0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                0:       floor_pick = W_FLOOR_ZERO;
                1:       floor_pick = pmnc_pkg::W_W'(1);
                2:       floor_pick = pmnc_pkg::W_ONE;
                3:       floor_pick = W_FLOOR_TOP;
                4:       floor_pick = pmnc_pkg::W_FLOOR_RESET;
                5:       floor_pick = pmnc_pkg::W_ONE - pmnc_pkg::W_W'(1);
                default: floor_pick = pmnc_pkg::W_W'($urandom_range(0, 65536));
            endcase
            write_floor(floor_pick);

            shape = hour_shape_t'($urandom_range(SHAPE_UNIFORM, SHAPE_SPIKES));
            burst = $urandom_range(40, 120);
            base  = pmnc_pkg::HIST_W'($urandom_range(0, 65535));
            for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
                if (sent >= RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
                case (shape)
                    SHAPE_UNIFORM: begin
                        conc = pmnc_pkg::HIST_W'($urandom_range(0, 65535));
                    end
                    SHAPE_NARROW: begin
                        conc = base - pmnc_pkg::HIST_W'($urandom_range(0, base >> 3));
                    end
                    SHAPE_LOW: begin
                        conc = pmnc_pkg::HIST_W'($urandom_range(0, 15));
                    end
                    SHAPE_RUNS: begin
                        // advance to a new run once the current one is used up
                        if (run_left == 0) begin
                            run_value = ($urandom_range(0, 2) == 0) ? '0
                                      : pmnc_pkg::HIST_W'($urandom_range(0, 65535));
                            run_left  = $urandom_range(1, 20);
                        end
                        conc     = run_value;
                        run_left = run_left - 1;
                    end
                    default: begin
                        conc = ($urandom_range(0, 9) == 0)
                             ? pmnc_pkg::HIST_W'(65535 - $urandom_range(0, 255))
                             : pmnc_pkg::HIST_W'($urandom_range(0, 255));
                    end
                endcase
                send_hour(conc);
                sent = sent + 1;
            end
        end

        // Drain, then watch a while longer for words nobody asked for.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
